[rtl/core/r64enc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r64enc_pkg: shared types and constants of the radix-64 armor encoder
// Job record passed from the front to the back, character slots, CRC-24
// step and radix-64 letter mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package r64enc_pkg;

  localparam int unsigned SlotCount = 10;
  localparam int unsigned SlotW     = 4;

  typedef logic [SlotW-1:0]     slot_t;
  typedef logic [SlotCount-1:0] slot_mask_t;

  typedef struct packed {
    logic       fin;
    logic [5:0] v0;
    logic [5:0] v1;
    logic [23:0] crc;
    slot_mask_t mask;
  } job_t;

  localparam logic CmdData   = 1'b0;
  localparam logic CmdFinish = 1'b1;

  localparam logic [23:0] CrcInit = 24'hB704CE;
  localparam logic [23:0] CrcPoly = 24'h864CFB;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChPad     = 8'h3D;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSlash   = 8'h2F;

  localparam slot_t SlotDataA   = 4'd0;
  localparam slot_t SlotDataNlA = 4'd1;
  localparam slot_t SlotDataB   = 4'd2;
  localparam slot_t SlotDataNlB = 4'd3;

  localparam slot_t SlotFinPad  = 4'd0;
  localparam slot_t SlotFinEqA  = 4'd1;
  localparam slot_t SlotFinEqB  = 4'd2;
  localparam slot_t SlotFinNl   = 4'd3;
  localparam slot_t SlotFinMark = 4'd4;
  localparam slot_t SlotFinC3   = 4'd5;
  localparam slot_t SlotFinC2   = 4'd6;
  localparam slot_t SlotFinC1   = 4'd7;
  localparam slot_t SlotFinC0   = 4'd8;
  localparam slot_t SlotFinEnd  = 4'd9;

  localparam slot_mask_t FinMaskOne   = 10'h3FF;
  localparam slot_mask_t FinMaskTwo   = 10'h3FB;
  localparam slot_mask_t FinMaskNl    = 10'h3F8;
  localparam slot_mask_t FinMaskPlain = 10'h3F0;

  function automatic logic [7:0] to_letter(input logic [5:0] v);
    logic [7:0] r;
    case (v) inside
      [6'd0:6'd25]:  r = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: r = 8'h47 + {2'b00, v};
      [6'd52:6'd61]: r = 8'hFC + {2'b00, v};
      6'd62:         r = ChPlus;
      default:       r = ChSlash;
    endcase
    return r;
  endfunction

  function automatic logic [23:0] crc24_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [23:0] c;
    logic        top;
    c = crc ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      top = c[23];
      c   = {c[22:0], 1'b0};
      if (top) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] char_at(input job_t job, input slot_t idx);
    logic [7:0] r;
    if (job.fin) begin
      case (idx)
        SlotFinPad:  r = to_letter(job.v0);
        SlotFinEqA:  r = ChPad;
        SlotFinEqB:  r = ChPad;
        SlotFinNl:   r = ChNewline;
        SlotFinMark: r = ChPad;
        SlotFinC3:   r = to_letter(job.crc[23:18]);
        SlotFinC2:   r = to_letter(job.crc[17:12]);
        SlotFinC1:   r = to_letter(job.crc[11:6]);
        SlotFinC0:   r = to_letter(job.crc[5:0]);
        default:     r = ChNewline;
      endcase
    end else begin
      case (idx)
        SlotDataA: r = to_letter(job.v0);
        SlotDataB: r = to_letter(job.v1);
        default:   r = ChNewline;
      endcase
    end
    return r;
  endfunction

  function automatic slot_t first_slot(input slot_mask_t m);
    slot_t r;
    r = '0;
    for (int j = SlotCount - 1; j >= 0; j--) begin
      if (m[j]) begin
        r = slot_t'(j);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/r64enc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r64enc_front: stream state and job builder
// Tracks group phase, line position and CRC-24, and turns each accepted
// beat into a job that lists the characters it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module r64enc_front #(
  parameter int unsigned LINE_WIDTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              command_i,
  input  wire logic [7:0]        data_byte_i,
  output r64enc_pkg::job_t       job_o
);

  localparam int unsigned PosW = $clog2(LINE_WIDTH);
  localparam logic [PosW-1:0] PosLast = PosW'(LINE_WIDTH - 1);

  logic [1:0]      phase_q, phase_d;
  logic [3:0]      prev_q, prev_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [23:0]     crc_q, crc_d;

  logic [1:0]      phase;
  logic            wrap_a, wrap_b;
  logic [PosW-1:0] pos_a;

  always_comb begin
    phase  = (phase_q == 2'd3) ? 2'd0 : phase_q;
    wrap_a = (pos_q == PosLast);
    pos_a  = wrap_a ? '0 : pos_q + PosW'(1);
    wrap_b = (pos_a == PosLast);

    phase_d = phase_q;
    prev_d  = prev_q;
    pos_d   = pos_q;
    crc_d   = crc_q;

    job_o     = '0;
    job_o.fin = (command_i == r64enc_pkg::CmdFinish);
    job_o.crc = crc_q;

    if (command_i == r64enc_pkg::CmdData) begin
      job_o.mask[r64enc_pkg::SlotDataA]   = 1'b1;
      job_o.mask[r64enc_pkg::SlotDataNlA] = wrap_a;
      case (phase)
        2'd0: begin
          job_o.v0 = data_byte_i[7:2];
          pos_d    = pos_a;
          phase_d  = 2'd1;
        end
        2'd1: begin
          job_o.v0 = {prev_q[1:0], data_byte_i[7:4]};
          pos_d    = pos_a;
          phase_d  = 2'd2;
        end
        default: begin
          job_o.v0 = {prev_q, data_byte_i[7:6]};
          job_o.v1 = data_byte_i[5:0];
          job_o.mask[r64enc_pkg::SlotDataB]   = 1'b1;
          job_o.mask[r64enc_pkg::SlotDataNlB] = wrap_b;
          pos_d    = wrap_b ? '0 : pos_a + PosW'(1);
          phase_d  = 2'd0;
        end
      endcase
      prev_d = data_byte_i[3:0];
      crc_d  = r64enc_pkg::crc24_byte(crc_q, data_byte_i);
    end else begin
      case (phase)
        2'd1: begin
          job_o.v0   = {prev_q[1:0], 4'h0};
          job_o.mask = r64enc_pkg::FinMaskOne;
        end
        2'd2: begin
          job_o.v0   = {prev_q, 2'b00};
          job_o.mask = r64enc_pkg::FinMaskTwo;
        end
        default: begin
          job_o.mask = (pos_q != '0) ? r64enc_pkg::FinMaskNl : r64enc_pkg::FinMaskPlain;
        end
      endcase
      phase_d = 2'd0;
      prev_d  = 4'h0;
      pos_d   = '0;
      crc_d   = r64enc_pkg::CrcInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      prev_q  <= 4'h0;
      pos_q   <= '0;
      crc_q   <= r64enc_pkg::CrcInit;
    end else if (accept_i) begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/r64enc_jobq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r64enc_jobq: job queue between front and back
// Small register queue; the head entry is visible while valid is high.
// ----------------------------------------------------------------------------
`default_nettype none

module r64enc_jobq #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire r64enc_pkg::job_t  job_i,
  output logic                   full_o,
  output logic                   valid_o,
  output r64enc_pkg::job_t       head_o,
  input  wire logic              pop_i
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam logic [AddrW-1:0] AddrLast = AddrW'(DEPTH - 1);
  localparam logic [CntW-1:0]  CntFull  = CntW'(DEPTH);

  r64enc_pkg::job_t slots_q [DEPTH];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  always_comb begin
    full_o   = (cnt_q == CntFull);
    valid_o  = (cnt_q != '0);
    head_o   = slots_q[rd_ptr_q];
    do_push  = push_i && !full_o;
    do_pop   = pop_i && valid_o;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrLast) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrLast) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/r64enc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r64enc_back: character sequencer
// Walks the slots of the head job into the output register, one character per
// cycle while it is empty or popped; releases the job with its last character.
// ----------------------------------------------------------------------------
`default_nettype none

module r64enc_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire r64enc_pkg::job_t  head_i,
  input  wire logic              head_valid_i,
  output logic                   pop_job_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output logic [7:0]             char_o,
  output logic                   last_o
);

  logic                   active_q, active_d;
  r64enc_pkg::slot_t      idx_q, idx_d;
  logic                   ovalid_q, ovalid_d;
  logic [7:0]             char_q;
  logic                   last_q;

  r64enc_pkg::slot_t      cur_idx;
  r64enc_pkg::slot_mask_t above;
  logic                   is_last;
  logic                   emit;

  always_comb begin
    cur_idx = active_q ? idx_q : r64enc_pkg::first_slot(head_i.mask);
    for (int j = 0; j < r64enc_pkg::SlotCount; j++) begin
      above[j] = head_i.mask[j] && (r64enc_pkg::slot_t'(j) > cur_idx);
    end
    is_last   = (above == '0);
    emit      = head_valid_i && (!ovalid_q || pop_i);
    pop_job_o = emit && is_last;

    active_d = active_q;
    idx_d    = idx_q;
    if (emit) begin
      active_d = !is_last;
      idx_d    = r64enc_pkg::first_slot(above);
    end

    ovalid_d = ovalid_q;
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (pop_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= r64enc_pkg::char_at(head_i, cur_idx);
      last_q <= is_last;
    end
  end

  assign empty_o = !ovalid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;

  a_active_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> head_valid_i)
    else $error("sequencer active without a queued job");

  a_active_slot_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> head_i.mask[idx_q])
    else $error("sequencer points at an unused slot");

  a_release_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_job_o |=> (ovalid_q && last_q))
    else $error("job released without a last character");

  a_emit_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> ovalid_q)
    else $error("emitted character not held in output register");

endmodule

`default_nettype wire

[rtl/core/radix64_armor_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix64_armor_encoder: streaming radix-64 armor encoder with CRC-24
// Input channel (push/full): one beat is a data byte (command 0) or a
// finish (command 1). Output channel (empty/pop): one ASCII character per
// beat, last_of_run_o set on the final character caused by an input beat.
// Three bytes give four characters, a newline ends every LINE_WIDTH
// characters; finish pads the open group, closes the line and appends '=',
// four checksum characters and a newline, then starts a fresh stream.
// With queue and output idle, an accepted beat is first written into the job
// queue and its first character is then loaded into the output register.
// The output register moves one character per cycle while pop is high or it
// is empty; a data byte gives one to three characters (about 1.4 on average),
// a finish six to ten. A two-entry job queue lets input run ahead of output.
// Reset empties the queue and output and loads the CRC initial value.
// While pop is held low the output holds its character, the queue fills
// and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module radix64_armor_encoder #(
  parameter int unsigned LINE_WIDTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       command_i,
  input  wire logic [7:0] data_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      char_out_o,
  output logic            last_of_run_o
);

  r64enc_pkg::job_t new_job;
  r64enc_pkg::job_t head_job;
  logic             head_valid;
  logic             pop_job;
  logic             accept;

  assign accept = push && !full;

  r64enc_front #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .job_o       (new_job)
  );

  r64enc_jobq #(
    .DEPTH(2)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .job_i   (new_job),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (head_job),
    .pop_i   (pop_job)
  );

  r64enc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .head_valid_i (head_valid),
    .pop_job_o    (pop_job),
    .pop_i        (pop),
    .empty_o      (empty),
    .char_o       (char_out_o),
    .last_o       (last_of_run_o)
  );

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the radix-64 armor encoder
// Pushes byte and finish beats through the push/full side and pops
// characters on the empty/pop side. A behavioral encoder with its own line
// counter and CRC-24 predicts every character and its end-of-run flag.
// A short table of hand-picked beats comes first, then random streams of
// mixed length. The sender runs in bursts and the receiver stalls in
// segments, with one long hold-off that backs the block up.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned LineWidth   = 64;
  localparam int unsigned RandomBeats = 390;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles  = 400;
  localparam logic [24:0] Crc24Poly   = 25'h1864CFB;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } armor_char_t;

  typedef struct {
    logic       cmd;
    logic [7:0] b;
    string      chars;
  } vector_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       command_i   = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       pop         = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] char_out_o;
  logic       last_of_run_o;

  logic [1:0]  enc_phase;
  logic [3:0]  enc_low;
  int unsigned enc_col;
  logic [23:0] enc_crc;

  logic [7:0]  run_chars[$];
  armor_char_t expected_chars[$];
  vector_t     vectors[$];

  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  int unsigned beats_sent   = 0;
  bit          random_phase = 1'b0;

  always #1 clk_i = ~clk_i;

  radix64_armor_encoder #(
    .LINE_WIDTH(LineWidth)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .empty        (empty),
    .pop          (pop),
    .char_out_o   (char_out_o),
    .last_of_run_o(last_of_run_o)
  );

  function automatic logic [7:0] radix64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + 8'(v);
    end else if (v < 6'd52) begin
      c = 8'h61 + 8'(v - 6'd26);
    end else if (v < 6'd62) begin
      c = 8'h30 + 8'(v - 6'd52);
    end else if (v == 6'd62) begin
      c = r64enc_pkg::ChPlus;
    end else begin
      c = r64enc_pkg::ChSlash;
    end
    return c;
  endfunction

  function automatic logic [23:0] crc24_next(input logic [23:0] crc, input logic [7:0] b);
    logic [24:0] acc;
    acc = {1'b0, crc ^ {b, 16'h0000}};
    for (int i = 0; i < 8; i++) begin
      acc = acc << 1;
      if (acc[24]) begin
        acc = acc ^ Crc24Poly;
      end
    end
    return acc[23:0];
  endfunction

  task automatic reset_encoder();
    enc_phase = 2'd0;
    enc_low   = 4'd0;
    enc_col   = 0;
    enc_crc   = r64enc_pkg::CrcInit;
  endtask

  task automatic put_data(input logic [5:0] v);
    run_chars.push_back(radix64_char(v));
    enc_col++;
    if (enc_col >= LineWidth) begin
      run_chars.push_back(r64enc_pkg::ChNewline);
      enc_col = 0;
    end
  endtask

  task automatic encode_beat(input logic cmd, input logic [7:0] b);
    logic [23:0] c;
    run_chars.delete();
    if (cmd == r64enc_pkg::CmdData) begin
      case (enc_phase)
        2'd1: put_data({enc_low[1:0], b[7:4]});
        2'd2: begin
          put_data({enc_low, b[7:6]});
          put_data(b[5:0]);
        end
        default: put_data(b[7:2]);
      endcase
      enc_phase = (enc_phase >= 2'd2) ? 2'd0 : enc_phase + 2'd1;
      enc_low   = b[3:0];
      enc_crc   = crc24_next(enc_crc, b);
    end else begin
      c = enc_crc;
      case (enc_phase)
        2'd1: begin
          run_chars.push_back(radix64_char({enc_low[1:0], 4'b0000}));
          run_chars.push_back(r64enc_pkg::ChPad);
          run_chars.push_back(r64enc_pkg::ChPad);
          run_chars.push_back(r64enc_pkg::ChNewline);
        end
        2'd2: begin
          run_chars.push_back(radix64_char({enc_low, 2'b00}));
          run_chars.push_back(r64enc_pkg::ChPad);
          run_chars.push_back(r64enc_pkg::ChNewline);
        end
        default: begin
          if (enc_col != 0) begin
            run_chars.push_back(r64enc_pkg::ChNewline);
          end
        end
      endcase
      run_chars.push_back(r64enc_pkg::ChPad);
      run_chars.push_back(radix64_char(c[23:18]));
      run_chars.push_back(radix64_char(c[17:12]));
      run_chars.push_back(radix64_char(c[11:6]));
      run_chars.push_back(radix64_char(c[5:0]));
      run_chars.push_back(r64enc_pkg::ChNewline);
      reset_encoder();
    end
  endtask

  task automatic add_vector(input logic cmd, input logic [7:0] b, input string chars);
    vector_t v;
    v.cmd   = cmd;
    v.b     = b;
    v.chars = chars;
    vectors.push_back(v);
  endtask

  // typed overrides the prediction when not empty
  task automatic offer_beat(input logic cmd, input logic [7:0] b, input string typed);
    int unsigned gap;
    int unsigned n;
    armor_char_t e;
    push        <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= b;
    do @(posedge clk_i); while (full);
    encode_beat(cmd, b);
    n = (typed.len() != 0) ? typed.len() : run_chars.size();
    for (int i = 0; i < n; i++) begin
      e.ch   = (typed.len() != 0) ? typed[i] : run_chars[i];
      e.last = (i == n - 1);
      expected_chars.push_back(e);
    end
    beats_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    int unsigned stream_len;
    add_vector(r64enc_pkg::CmdFinish, 8'h00, "=twTO\n");
    add_vector(r64enc_pkg::CmdFinish, 8'hFF, "=twTO\n");
    add_vector(r64enc_pkg::CmdData,   8'hFF, "/");
    add_vector(r64enc_pkg::CmdData,   8'h00, "");
    add_vector(r64enc_pkg::CmdData,   8'hFF, "");
    add_vector(r64enc_pkg::CmdFinish, 8'h00, "");
    add_vector(r64enc_pkg::CmdData,   8'h00, "A");
    add_vector(r64enc_pkg::CmdFinish, 8'hFF, "");
    add_vector(r64enc_pkg::CmdData,   8'hA5, "");
    add_vector(r64enc_pkg::CmdData,   8'h5A, "");
    add_vector(r64enc_pkg::CmdFinish, 8'h00, "");
    add_vector(r64enc_pkg::CmdData,   8'h80, "");
    add_vector(r64enc_pkg::CmdData,   8'h7F, "");
    add_vector(r64enc_pkg::CmdData,   8'h01, "");
    add_vector(r64enc_pkg::CmdData,   8'hFE, "");
    add_vector(r64enc_pkg::CmdFinish, 8'h55, "");
    add_vector(r64enc_pkg::CmdData,   8'h00, "A");
    add_vector(r64enc_pkg::CmdData,   8'h00, "A");
    add_vector(r64enc_pkg::CmdData,   8'h00, "AA");
    add_vector(r64enc_pkg::CmdFinish, 8'hAA, "");
    reset_encoder();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (vectors[k]) begin
      offer_beat(vectors[k].cmd, vectors[k].b, vectors[k].chars);
    end
    random_phase = 1'b1;
    while (beats_sent < vectors.size() + RandomBeats) begin
      case ($urandom_range(0, 9)) inside
        0:       stream_len = 0;
        [1:4]:   stream_len = $urandom_range(1, 6);
        [5:7]:   stream_len = $urandom_range(7, 60);
        default: stream_len = $urandom_range(61, 140);
      endcase
      if (stream_len > vectors.size() + RandomBeats - beats_sent) begin
        stream_len = vectors.size() + RandomBeats - beats_sent;
      end
      repeat (stream_len) offer_beat(r64enc_pkg::CmdData, 8'($urandom), "");
      // merge into the next stream now and then
      if ($urandom_range(0, 5) != 0) begin
        offer_beat(r64enc_pkg::CmdFinish, 8'($urandom), "");
      end
    end
    offer_beat(r64enc_pkg::CmdFinish, 8'($urandom), "");
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int unsigned seg_left;
    int unsigned pop_odds;
    int unsigned hold_left;
    int unsigned hold_delay;
    bit          hold_done;
    armor_char_t e;
    seg_left   = 0;
    pop_odds   = 1;
    hold_left  = 0;
    hold_delay = 40;
    hold_done  = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $error("char_out: expected nothing, got %h", char_out_o);
          mismatches++;
        end else begin
          e = expected_chars.pop_front();
          if (char_out_o !== e.ch) begin
            $error("char_out: expected %h, got %h", e.ch, char_out_o);
            mismatches++;
          end
          if (last_of_run_o !== e.last) begin
            $error("last_of_run: expected %b, got %b", e.last, last_of_run_o);
            mismatches++;
          end
        end
      end
      // hold off once so the block backs up
      if (random_phase && !hold_done) begin
        if (hold_delay == 0) begin
          hold_left = HoldCycles;
          hold_done = 1'b1;
        end else begin
          hold_delay--;
        end
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0:       pop_odds = 1;
          1:       pop_odds = 2;
          default: pop_odds = 5;
        endcase
      end else begin
        seg_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(1, pop_odds) == 1);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

[radix64_armor_encoder.f]
rtl/core/r64enc_pkg.sv
rtl/core/r64enc_front.sv
rtl/core/r64enc_jobq.sv
rtl/core/r64enc_back.sv
rtl/core/radix64_armor_encoder.sv
tb/tb_top.sv
